[rtl/decimal_to_signed_binary_code_assert.svh]
// Assertion macros used by the converter top level.
`ifndef DECIMAL_TO_SIGNED_BINARY_CODE_ASSERT_SVH
`define DECIMAL_TO_SIGNED_BINARY_CODE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define DSBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset.
`define DSBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DSBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DSBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/dsbc_pkg.sv]
// Shared constants and types of the decimal to signed binary code converter.
`default_nettype none

package dsbc_pkg;

	localparam int unsigned DSBC_DIGIT_W   = 4;
	localparam int unsigned DSBC_ACC_W     = 60;
	localparam int unsigned DSBC_WORD_W    = 62;
	localparam int unsigned DSBC_LEN_W     = 6;
	localparam int unsigned DSBC_COUNT_W   = 5;
	localparam int unsigned DSBC_KIND_W    = 2;
	localparam int unsigned DSBC_NIBBLE    = 4;
	localparam int unsigned DSBC_MAX_DIGITS = 18;

	localparam logic [DSBC_DIGIT_W-1:0] DSBC_DIGIT_MAX = 4'd9;

	typedef enum logic [DSBC_KIND_W-1:0] {
		KIND_DIRECT     = 2'd0,
		KIND_REVERSE    = 2'd1,
		KIND_ADDITIONAL = 2'd2
	} dsbc_kind_t;

	typedef enum logic [1:0] {
		ST_TAKE,
		ST_SCAN,
		ST_EMIT
	} dsbc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic start;
		logic step;
		logic emit;
	} dsbc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
	} dsbc_sts_t;

endpackage

`default_nettype wire

[rtl/dsbc_channels.sv]
// Handshake channel interfaces: digit input, code output and configuration write.
`default_nettype none

interface dsbc_digit_if import dsbc_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [DSBC_DIGIT_W-1:0] digit;
	logic                    negative;
	logic                    last;

	modport source (output valid, output digit, output negative, output last, input ready);
	modport sink   (input valid, input digit, input negative, input last, output ready);
endinterface

interface dsbc_code_if import dsbc_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [DSBC_WORD_W-1:0] code_word;
	logic [DSBC_LEN_W-1:0]  code_length;
	logic                   overflow;

	modport source (output valid, output code_word, output code_length, output overflow,
		input ready);
	modport sink   (input valid, input code_word, input code_length, input overflow,
		output ready);
endinterface

interface dsbc_cfg_if import dsbc_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic [DSBC_KIND_W-1:0] code_kind;

	modport source (output valid, output code_kind, input ready);
	modport sink   (input valid, input code_kind, output ready);
endinterface

`default_nettype wire

[rtl/dsbc_ctrl.sv]
// Controller state machine: digit intake, bit-count scan and result hand-off.
`default_nettype none

module dsbc_ctrl import dsbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dsbc_sts_t sts,
	output dsbc_cmd_t cmd
);

	dsbc_state_t state_q;
	dsbc_state_t state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TAKE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_TAKE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				cmd.start  = in_valid && in_last;
				if (in_valid && in_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// wait for the output register to be free
				cmd.emit = !out_valid_q || out_ready;
				if (!out_valid_q || out_ready) begin
					state_d = ST_TAKE;
				end
			end
			default: begin
				state_d = ST_TAKE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

[rtl/dsbc_datapath.sv]
// Datapath: decimal accumulator, leading-one scan and code word formatting.
`default_nettype none

module dsbc_datapath import dsbc_pkg::*; #(
	parameter int unsigned MAX_DIGITS = DSBC_MAX_DIGITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dsbc_cmd_t               cmd,
	output dsbc_sts_t               sts,
	input  logic [DSBC_DIGIT_W-1:0] digit,
	input  logic                    negative,
	input  logic                    cfg_we,
	input  logic [DSBC_KIND_W-1:0]  cfg_kind,
	output logic [DSBC_WORD_W-1:0]  code_word,
	output logic [DSBC_LEN_W-1:0]   code_length,
	output logic                    overflow
);

	localparam int unsigned ACC_W = DSBC_ACC_W;
	localparam int unsigned LEN_W = DSBC_LEN_W;
	localparam int unsigned WORD_W = DSBC_WORD_W;

	function automatic logic [1:0] lead_zeros(input logic [DSBC_NIBBLE-1:0] nib);
		logic [1:0] n;
		begin
			n = 2'd0;
			if (nib[3]) begin
				n = 2'd0;
			end else if (nib[2]) begin
				n = 2'd1;
			end else if (nib[1]) begin
				n = 2'd2;
			end else if (nib[0]) begin
				n = 2'd3;
			end
			return n;
		end
	endfunction

	logic [ACC_W-1:0]        acc_q;
	logic [DSBC_COUNT_W-1:0] count_q;
	logic                    flag_q;
	logic [DSBC_KIND_W-1:0]  kind_q;
	logic                    neg_q;
	logic [ACC_W-1:0]        scan_q;
	logic [LEN_W-1:0]        bcnt_q;
	logic [WORD_W-1:0]       word_q;
	logic [LEN_W-1:0]        len_q;
	logic                    ovf_q;

	logic [DSBC_DIGIT_W-1:0] d_sat;
	logic                    significant;
	logic                    full;
	logic [ACC_W-1:0]        acc_d;
	logic [DSBC_NIBBLE-1:0]  top_nib;
	logic                    done;

	logic [WORD_W-1:0] mag;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] sign_bit;
	logic [WORD_W-1:0] body;
	logic              invert;
	logic              add_one;
	logic [WORD_W-1:0] word_d;
	logic [LEN_W-1:0]  len_d;

	// Accumulate: acc * 10 + d as two shifted copies plus the digit.
	assign d_sat       = (digit > DSBC_DIGIT_MAX) ? DSBC_DIGIT_MAX : digit;
	assign significant = !(count_q == '0 && d_sat == '0);
	assign full        = count_q >= DSBC_COUNT_W'(MAX_DIGITS);
	assign acc_d       = {acc_q[ACC_W-4:0], 3'b000} + {acc_q[ACC_W-2:0], 1'b0}
		+ ACC_W'(d_sat);

	// Scan one nibble a step from the top for the highest set bit.
	assign top_nib       = scan_q[ACC_W-1 -: DSBC_NIBBLE];
	assign done          = (top_nib != '0) || (bcnt_q == '0);
	assign sts.scan_done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			count_q <= '0;
			flag_q  <= 1'b0;
			kind_q  <= KIND_DIRECT;
		end else begin
			if (cfg_we) begin
				kind_q <= cfg_kind;
			end
			if (cmd.emit) begin
				acc_q   <= '0;
				count_q <= '0;
				flag_q  <= 1'b0;
			end else if (cmd.accept && significant) begin
				if (full) begin
					flag_q <= 1'b1;
				end else begin
					acc_q   <= acc_d;
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			scan_q <= (significant && !full) ? acc_d : acc_q;
			bcnt_q <= LEN_W'(ACC_W);
			neg_q  <= negative;
		end else if (cmd.step) begin
			if (done) begin
				bcnt_q <= bcnt_q - LEN_W'(lead_zeros(top_nib));
			end else begin
				scan_q <= scan_q << DSBC_NIBBLE;
				bcnt_q <= bcnt_q - LEN_W'(DSBC_NIBBLE);
			end
		end
		if (cmd.emit) begin
			word_q <= word_d;
			len_q  <= len_d;
			ovf_q  <= flag_q;
		end
	end

	// Sign, zero bit, magnitude; negative: reverse ~m, additional ~m+1.
	assign mag      = {{(WORD_W-ACC_W){1'b0}}, acc_q};
	assign mask     = ~({WORD_W{1'b1}} << (bcnt_q + 1'b1));
	assign sign_bit = WORD_W'(neg_q) << (bcnt_q + 1'b1);
	assign invert   = neg_q && (kind_q inside {KIND_REVERSE, KIND_ADDITIONAL});
	assign add_one  = neg_q && (kind_q == KIND_ADDITIONAL);
	assign body     = invert ? (~mag & mask) : mag;
	assign word_d   = (sign_bit | body) + WORD_W'(add_one);
	// only negative zero carries out of the sign bit
	assign len_d    = bcnt_q + LEN_W'(2) + LEN_W'(add_one && bcnt_q == '0);

	assign code_word   = word_q;
	assign code_length = len_q;
	assign overflow    = ovf_q;

endmodule

`default_nettype wire

[rtl/decimal_to_signed_binary_code.sv]
// n digits take n transfers; the last is followed by the bit-count scan and the format step.
// The scan checks one nibble of the 60-bit magnitude per cycle, stopping at the first nonzero nibble or the end.
// One digit per cycle in intake; intake closes during scan and format, which waits on a full output register.
// Reset (arst_n low, asynchronous): accumulator, digit count, state cleared; code_kind set to direct.
`default_nettype none

`include "decimal_to_signed_binary_code_assert.svh"

module decimal_to_signed_binary_code import dsbc_pkg::*; #(
	parameter int unsigned MAX_DIGITS = DSBC_MAX_DIGITS
) (
	input  logic          clk,
	input  logic          arst_n,
	dsbc_digit_if.sink    digits,
	dsbc_code_if.source   codes,
	dsbc_cfg_if.sink      cfg
);

	// Command and status between controller and datapath.
	dsbc_cmd_t cmd;
	dsbc_sts_t sts;

	// Configuration transfers are always taken; the user must write only while idle, the block does not enforce it.
	assign cfg.ready = 1'b1;

	// Controller: holds the digit channel open in intake, advances through the
	// scan, and loads the output register only once the previous result is taken.
	dsbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (digits.valid),
		.in_last   (digits.last),
		.in_ready  (digits.ready),
		.out_valid (codes.valid),
		.out_ready (codes.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: accumulates digits, finds the bit count and formats the code.
	dsbc_datapath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.digit       (digits.digit),
		.negative    (digits.negative),
		.cfg_we      (cfg.valid),
		.cfg_kind    (cfg.code_kind),
		.code_word   (codes.code_word),
		.code_length (codes.code_length),
		.overflow    (codes.overflow)
	);

	// Intake is closed in the cycle after the final digit of a number.
	`DSBC_ASSERT_NXT(a_close_after_last, clk, arst_n, digits.valid && digits.ready && digits.last, !digits.ready, "digit channel open right after last transfer")
	// Load a new result only into a free or draining output register.
	`DSBC_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit, !codes.valid || codes.ready, "result overwritten before transfer")
	// No code bits above the stated length.
	`DSBC_ASSERT_IMP(a_word_fits, clk, arst_n, codes.valid, (codes.code_word >> codes.code_length) == '0, "code word wider than its length")
	// Length stays within sign, zero bit and the widest magnitude.
	`DSBC_ASSERT_IMP(a_len_range, clk, arst_n, codes.valid, codes.code_length >= 6'd2 && codes.code_length <= 6'd62, "code length out of range")

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for the decimal to signed binary code converter, self-checking against its own predictor.
import dsbc_pkg::*;

module tb;

	// Code kind 3 is not named in the package; the block treats it as direct.
	localparam logic [DSBC_KIND_W-1:0] KIND_SPARE = 2'd3;
	// Scan plus format cycles after a last digit, with margin for a busy block.
	localparam int unsigned SETTLE_CYCLES = 24;
	localparam int unsigned ITEMS_PER_PHASE = 200;
	localparam int unsigned PHASES = 8;

	typedef struct packed {
		logic [DSBC_DIGIT_W-1:0] digit;
		logic                    negative;
		logic                    last;
	} digit_item_t;

	typedef struct packed {
		logic [DSBC_WORD_W-1:0] code_word;
		logic [DSBC_LEN_W-1:0]  code_length;
		logic                   overflow;
	} code_item_t;

	logic clk;
	logic arst_n;

	dsbc_digit_if digits();
	dsbc_code_if  codes();
	dsbc_cfg_if   cfg();

	decimal_to_signed_binary_code uut (
		.clk    (clk),
		.arst_n (arst_n),
		.digits (digits),
		.codes  (codes),
		.cfg    (cfg)
	);

	// Digits waiting to be offered, and code words the predictor has worked out.
	digit_item_t pending_digits [$];
	code_item_t  expected_codes [$];

	// Predictor state: a private copy of the accumulator and the code kind.
	logic [DSBC_ACC_W-1:0]  acc_mag;
	int unsigned            sig_count;
	logic                   dropped_digit;
	logic [DSBC_KIND_W-1:0] kind_now;

	int unsigned mismatches;
	int unsigned queued_items;

	// Sender and receiver pacing.
	logic        digit_moved;
	logic        hold_off;
	logic        steady_send;
	logic        steady_take;
	int unsigned burst_left;
	int unsigned gap_left;
	int unsigned stall_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Fold one accepted digit into the predictor; on the last digit build the code word.
	task automatic absorb_digit(input digit_item_t it);
		logic [DSBC_DIGIT_W-1:0] d;
		logic [63:0]             mask;
		logic [63:0]             body;
		logic [63:0]             word;
		int unsigned             nbits;
		int unsigned             len;
		code_item_t              res;
		// Saturate anything above nine.
		d = (it.digit > DSBC_DIGIT_MAX) ? DSBC_DIGIT_MAX : it.digit;
		// Ignore leading zeros; drop significant digits beyond the limit.
		if (!(sig_count == 0 && d == '0)) begin
			if (sig_count >= DSBC_MAX_DIGITS) begin
				dropped_digit = 1'b1;
			end else begin
				acc_mag = acc_mag * 60'd10 + {56'd0, d};
				sig_count++;
			end
		end
		if (it.last) begin
			nbits = 0;
			for (int i = 0; i < DSBC_ACC_W; i++) begin
				if (acc_mag[i])
					nbits = i + 1;
			end
			len = nbits + 2;
			// Magnitude plus the zero bit above it.
			mask = (64'd1 << (nbits + 1)) - 64'd1;
			body = {4'd0, acc_mag} & mask;
			if (it.negative && (kind_now == KIND_REVERSE || kind_now == KIND_ADDITIONAL))
				body = ~{4'd0, acc_mag} & mask;
			word = (it.negative ? (64'd1 << (nbits + 1)) : 64'd0) | body;
			// Carry out of the sign lengthens the word (negative zero).
			if (it.negative && kind_now == KIND_ADDITIONAL) begin
				word = word + 64'd1;
				if ((word >> len) != 64'd0)
					len++;
			end
			res.code_word   = word[DSBC_WORD_W-1:0];
			res.code_length = len[DSBC_LEN_W-1:0];
			res.overflow    = dropped_digit;
			expected_codes = {expected_codes, res};
			acc_mag       = '0;
			sig_count     = 0;
			dropped_digit = 1'b0;
		end
	endtask

	task automatic push_digit(input logic [DSBC_DIGIT_W-1:0] d, input logic neg, input logic fin);
		digit_item_t it;
		it.digit    = d;
		it.negative = neg;
		it.last     = fin;
		pending_digits = {pending_digits, it};
		queued_items++;
	endtask

	// Queue one number: leading zeros, then sig significant digits, the sign on the last.
	task automatic queue_number(input int unsigned sig, input int unsigned zeros, input logic neg);
		digit_item_t its [$];
		digit_item_t it;
		for (int unsigned i = 0; i < zeros + sig; i++) begin
			if (i < zeros)
				it.digit = '0;
			else if (i == zeros)
				it.digit = DSBC_DIGIT_W'($urandom_range(1, 9));
			else
				it.digit = DSBC_DIGIT_W'($urandom_range(0, 9));
			// Now and then an out-of-range digit, which saturates.
			if (i >= zeros && $urandom_range(0, 11) == 0)
				it.digit = DSBC_DIGIT_W'($urandom_range(10, 15));
			// Sign on earlier digits is noise.
			it.negative = 1'($urandom_range(0, 1));
			it.last     = 1'b0;
			its = {its, it};
		end
		if (its.size() == 0) begin
			it.digit    = '0;
			it.negative = 1'b0;
			it.last     = 1'b0;
			its = {its, it};
		end
		its[its.size()-1].last     = 1'b1;
		its[its.size()-1].negative = neg;
		foreach (its[i])
			push_digit(its[i].digit, its[i].negative, its[i].last);
	endtask

	// Block until the sender is quiet, every predicted code word has been taken and, with need_empty, no digit is pending.
	task automatic wait_quiet(input logic need_empty);
		do
			@(negedge clk);
		while (digits.valid || expected_codes.size() != 0
			|| (need_empty && pending_digits.size() != 0));
	endtask

	// Write the code kind over the configuration channel; only called with the block idle.
	task automatic write_kind(input logic [DSBC_KIND_W-1:0] k);
		@(negedge clk);
		cfg.valid     <= 1'b1;
		cfg.code_kind <= k;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		kind_now = k;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [DSBC_KIND_W-1:0] kind_for_phase(input int unsigned p);
		case (p)
			0: kind_for_phase = KIND_ADDITIONAL;
			1: kind_for_phase = KIND_REVERSE;
			2: kind_for_phase = KIND_SPARE;
			3: kind_for_phase = KIND_DIRECT;
			4: kind_for_phase = KIND_ADDITIONAL;
			5: kind_for_phase = KIND_REVERSE;
			6: kind_for_phase = KIND_DIRECT;
			default: kind_for_phase = KIND_ADDITIONAL;
		endcase
	endfunction

	// Transfer detection and checking, sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n && digits.valid && digits.ready) begin
			absorb_digit(pending_digits.pop_front());
			digit_moved = 1'b1;
		end
		if (arst_n && codes.valid && codes.ready) begin
			if (expected_codes.size() == 0) begin
				$error("unexpected code word %h, length %0d", codes.code_word, codes.code_length);
				mismatches++;
			end else begin
				code_item_t exp_code;
				exp_code = expected_codes.pop_front();
				if (codes.code_word !== exp_code.code_word) begin
					$error("code_word: expected %h, got %h", exp_code.code_word, codes.code_word);
					mismatches++;
				end
				if (codes.code_length !== exp_code.code_length) begin
					$error("code_length: expected %0d, got %0d", exp_code.code_length,
						codes.code_length);
					mismatches++;
				end
				if (codes.overflow !== exp_code.overflow) begin
					$error("overflow: expected %b, got %b", exp_code.overflow, codes.overflow);
					mismatches++;
				end
			end
		end
	end

	// Digit driver: hold an offered digit until its transfer, otherwise send in bursts.
	always @(negedge clk) begin
		if (!arst_n || !digits.valid || digit_moved) begin
			if (arst_n && !hold_off && gap_left == 0 && pending_digits.size() != 0) begin
				digits.valid    <= 1'b1;
				digits.digit    <= pending_digits[0].digit;
				digits.negative <= pending_digits[0].negative;
				digits.last     <= pending_digits[0].last;
				// End of burst: pick the next burst and the gap before it.
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = (steady_send || $urandom_range(0, 3) == 0) ? 0
						: $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				digits.valid <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end
		end
		digit_moved = 1'b0;
	end

	// Code receiver: random runs of stalls, none while steady_take is set.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			codes.ready <= 1'b0;
			stall_left--;
		end else begin
			codes.ready <= 1'b1;
			if (!steady_take && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 10);
		end
	end

	initial begin
		int unsigned r;
		int unsigned sig;
		int unsigned zeros;
		// Drive every input to a known value from time zero.
		arst_n          = 1'b0;
		digits.valid    = 1'b0;
		digits.digit    = '0;
		digits.negative = 1'b0;
		digits.last     = 1'b0;
		codes.ready     = 1'b0;
		cfg.valid       = 1'b0;
		cfg.code_kind   = KIND_DIRECT;
		acc_mag         = '0;
		sig_count       = 0;
		dropped_digit   = 1'b0;
		kind_now        = KIND_DIRECT;
		mismatches      = 0;
		queued_items    = 0;
		digit_moved     = 1'b0;
		hold_off        = 1'b0;
		steady_send     = 1'b0;
		steady_take     = 1'b0;
		burst_left      = 0;
		gap_left        = 0;
		stall_left      = 0;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Directed part, direct code as after reset.
		push_digit(4'd0, 1'b0, 1'b1);            // positive zero
		push_digit(4'd0, 1'b1, 1'b1);            // negative zero
		push_digit(4'd15, 1'b1, 1'b1);           // saturates to nine
		push_digit(4'd0, 1'b1, 1'b0);            // leading zeros ignored
		push_digit(4'd0, 1'b0, 1'b0);
		push_digit(4'd7, 1'b1, 1'b1);
		// Nineteen nines: widest magnitude kept, the last one dropped.
		for (int i = 0; i < 19; i++)
			push_digit(4'd9, 1'b1, i == 18);
		wait_quiet(1'b1);
		repeat (SETTLE_CYCLES) @(negedge clk);

		for (int unsigned p = 0; p < PHASES; p++) begin
			write_kind(kind_for_phase(p));
			steady_send = (p == 3);
			steady_take = (p == 5);
			queued_items = 0;
			// Zero of both signs and a small negative under each kind.
			push_digit(4'd0, 1'b1, 1'b1);
			push_digit(4'd0, 1'b0, 1'b1);
			push_digit(4'd1, 1'b1, 1'b1);
			while (queued_items < ITEMS_PER_PHASE) begin
				r     = $urandom_range(0, 99);
				zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
				if (r < 6)
					sig = 0;
				else if (r < 45)
					sig = $urandom_range(1, 5);
				else if (r < 85)
					sig = $urandom_range(6, DSBC_MAX_DIGITS);
				else
					sig = $urandom_range(DSBC_MAX_DIGITS + 1, DSBC_MAX_DIGITS + 4);
				queue_number(sig, zeros, 1'($urandom_range(0, 1)));
			end
			// Once, halfway through, pause the sender until every code word is back.
			if (p == 2) begin
				while (pending_digits.size() > ITEMS_PER_PHASE / 2)
					@(negedge clk);
				hold_off = 1'b1;
				wait_quiet(1'b0);
				hold_off = 1'b0;
			end
			wait_quiet(1'b1);
			repeat (SETTLE_CYCLES) @(negedge clk);
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/dsbc_pkg.sv
rtl/dsbc_channels.sv
rtl/dsbc_ctrl.sv
rtl/dsbc_datapath.sv
rtl/decimal_to_signed_binary_code.sv
tb/tb.sv
